@@ hw/rtl/bvh_pkg.sv @@
// Shared types and constants of the binomial valuation histogram block.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package bvh_pkg;

  localparam int M_W    = 40;
  localparam int BASE_W = 8;
  localparam int VAL_W  = 6;
  localparam int CNT_W  = 41;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef struct packed {
    logic              last;
    logic              has_digit;
    logic [BASE_W-1:0] digit;
    logic [BASE_W-1:0] base;
  } q_entry_t;

endpackage

`default_nettype wire

@@ hw/rtl/bvh_front.sv @@
// Front end: accepts items and splits m into base-p digits, one byte of m per cycle.
// A full bvh_fifo can hold the byte division back. Depends on bvh_pkg; feeds bvh_fifo.
`timescale 1ns / 1ps
`default_nettype none

module bvh_front #(
  parameter int M_BITS = 40
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire  [bvh_pkg::M_W-1:0]        m_value_i,
  input  wire  [bvh_pkg::BASE_W-1:0]     base_i,
  output logic                           push_o,
  output bvh_pkg::q_entry_t              entry_o,
  input  wire                            full_i
);
  import bvh_pkg::*;

  localparam int NB  = (M_BITS + 7) / 8;
  localparam int NBW = NB * 8;
  localparam int IW  = (NB > 1) ? $clog2(NB) : 1;

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_DIV  = 2'b10
  } fstate_e;

  typedef struct packed {
    logic [7:0] q;
    logic [7:0] r;
  } div_t;

  function automatic div_t div_byte(input logic [7:0] r, input logic [7:0] b,
                                    input logic [7:0] p);
    logic [8:0] acc;
    div_t       res;
    acc = {1'b0, r};
    res = '0;
    for (int i = 7; i >= 0; i--) begin
      acc = {acc[7:0], b[i]};
      if (acc >= {1'b0, p}) begin
        acc = acc - {1'b0, p};
        res.q[i] = 1'b1;
      end
    end
    res.r = acc[7:0];
    return res;
  endfunction

  fstate_e              state_q, state_d;
  logic [NB-1:0][7:0]   bytes_q;
  logic [7:0]           base_q;
  logic [7:0]           rem_q;
  logic [IW-1:0]        idx_q;
  logic [IW-1:0]        top_q;
  logic                 qtz_q;

  logic [M_BITS-1:0]    n_load;
  logic [NB-1:0][7:0]   n_bytes;
  logic [IW-1:0]        load_top;
  logic [7:0]           base_fix;
  logic                 in_acc;
  logic                 step;
  div_t                 dv;
  logic                 qz_top;
  logic                 done;
  logic [IW-1:0]        new_top;

  assign n_load   = M_BITS'(m_value_i);
  assign n_bytes  = NBW'(n_load);
  assign base_fix = (base_i < 8'd2) ? 8'd2 : base_i;

  always_comb begin
    load_top = '0;
    for (int i = 0; i < NB; i++) begin
      if (n_bytes[i] != 8'd0) begin
        load_top = IW'(i);
      end
    end
  end

  assign in_stall_o = (state_q != F_IDLE) || full_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign dv      = div_byte(rem_q, bytes_q[idx_q], base_q);
  assign qz_top  = (idx_q == top_q) ? (dv.q == 8'd0) : qtz_q;
  assign done    = (top_q == '0) && (dv.q == 8'd0);
  assign new_top = (qz_top && (top_q != '0)) ? top_q - IW'(1) : top_q;
  assign step    = (state_q == F_DIV) && ((idx_q != '0) || !full_i);

  always_comb begin
    push_o  = 1'b0;
    entry_o = '0;
    state_d = state_q;
    unique case (state_q)
      F_IDLE: begin
        if (in_acc) begin
          if (n_bytes == '0) begin
            push_o          = 1'b1;
            entry_o.last    = 1'b1;
            entry_o.base    = base_fix;
          end else begin
            state_d = F_DIV;
          end
        end
      end
      F_DIV: begin
        if (step && (idx_q == '0)) begin
          push_o            = 1'b1;
          entry_o.last      = done;
          entry_o.has_digit = 1'b1;
          entry_o.digit     = dv.r;
          entry_o.base      = base_q;
          if (done) begin
            state_d = F_IDLE;
          end
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (state_q == F_IDLE)) begin
      bytes_q <= n_bytes;
      base_q  <= base_fix;
      rem_q   <= 8'd0;
      idx_q   <= load_top;
      top_q   <= load_top;
      qtz_q   <= 1'b0;
    end else if (step) begin
      bytes_q[idx_q] <= dv.q;
      qtz_q          <= qz_top;
      if (idx_q == '0) begin
        rem_q <= 8'd0;
        idx_q <= new_top;
        top_q <= new_top;
      end else begin
        rem_q <= dv.r;
        idx_q <= idx_q - IW'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_DIV) |-> (rem_q < base_q) && (base_q >= 8'd2))
    else $error("Partial remainder is not below the base.");

endmodule

`default_nettype wire

@@ hw/rtl/bvh_fifo.sv @@
// Short queue of digit items between the front end and the histogram back end.
// Depends on bvh_pkg for the item type and the depth.
`timescale 1ns / 1ps
`default_nettype none

module bvh_fifo (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  bvh_pkg::q_entry_t  entry_i,
  output logic               full_o,
  input  wire                pop_i,
  output bvh_pkg::q_entry_t  head_o,
  output logic               empty_o
);
  import bvh_pkg::*;

  q_entry_t          mem_q [Q_DEPTH];
  logic [Q_AW-1:0]   wr_q;
  logic [Q_AW-1:0]   rd_q;
  logic [Q_AW:0]     cnt_q;

  assign full_o  = (cnt_q == (Q_AW + 1)'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + Q_AW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + Q_AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (Q_AW + 1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (Q_AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("Item pushed into a full queue.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("Item popped from an empty queue.");

endmodule

`default_nettype wire

@@ hw/rtl/bvh_back.sv @@
// Back end: digit DP over borrow and no-borrow count vectors, then histogram output.
// Depends on bvh_pkg; consumes items from bvh_fifo.
`timescale 1ns / 1ps
`default_nettype none

module bvh_back #(
  parameter int M_BITS = 40
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  bvh_pkg::q_entry_t            head_i,
  input  wire                          empty_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [bvh_pkg::VAL_W-1:0]    valuation_o,
  output logic [bvh_pkg::CNT_W-1:0]    count_o,
  output logic                         last_o
);
  import bvh_pkg::*;

  localparam int NV = M_BITS + 1;
  localparam int VW = $clog2(NV);

  typedef enum logic [1:0] {
    B_RUN  = 2'b01,
    B_EMIT = 2'b10
  } bstate_e;

  bstate_e             state_q;
  logic [CNT_W-1:0]    keep_q [NV];
  logic [CNT_W-1:0]    owe_q  [NV];
  logic [CNT_W-1:0]    keep_d [NV];
  logic [CNT_W-1:0]    owe_d  [NV];
  logic [NV-1:0]       knz_q, onz_q, knz_d, onz_d;
  logic [VW-1:0]       v_q;
  logic                out_valid_q;
  logic [VAL_W-1:0]    val_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                last_q;

  logic [7:0]          fa, fb, fc, fe;
  logic                d_nz, d_max;
  logic                update;
  logic                out_free;
  logic                emit;
  logic                is_last;

  assign pop_o  = (state_q == B_RUN) && !empty_i;
  assign update = pop_o && head_i.has_digit;

  assign fa    = head_i.digit + 8'd1;
  assign fb    = head_i.base - 8'd1 - head_i.digit;
  assign fc    = head_i.digit;
  assign fe    = head_i.base - head_i.digit;
  assign d_nz  = (head_i.digit != 8'd0);
  assign d_max = (head_i.digit == head_i.base - 8'd1);

  for (genvar v = 0; v < NV; v++) begin : g_lane
    assign keep_d[v] = keep_q[v] * CNT_W'(fa) + owe_q[v] * CNT_W'(fc);
    assign knz_d[v]  = knz_q[v] | (onz_q[v] & d_nz);
    if (v == 0) begin : g_first
      assign owe_d[v] = '0;
      assign onz_d[v] = 1'b0;
    end else begin : g_rest
      assign owe_d[v] = keep_q[v-1] * CNT_W'(fb) + owe_q[v-1] * CNT_W'(fe);
      assign onz_d[v] = (knz_q[v-1] & !d_max) | onz_q[v-1];
    end
  end

  // While the histogram is sent, the no-borrow vector shifts down by one bin per bin sent,
  // so the current bin is always lane zero.
  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = (state_q == B_EMIT) && out_free;
  assign is_last  = (knz_q[NV-1:1] == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_RUN;
      v_q         <= '0;
      out_valid_q <= 1'b0;
      knz_q       <= NV'(1);
      onz_q       <= '0;
      for (int i = 0; i < NV; i++) begin
        keep_q[i] <= (i == 0) ? CNT_W'(1) : '0;
        owe_q[i]  <= '0;
      end
    end else begin
      if (update) begin
        knz_q <= knz_d;
        onz_q <= onz_d;
        for (int i = 0; i < NV; i++) begin
          keep_q[i] <= keep_d[i];
          owe_q[i]  <= owe_d[i];
        end
      end
      if (pop_o && head_i.last) begin
        state_q <= B_EMIT;
        v_q     <= '0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
        if (is_last) begin
          state_q <= B_RUN;
          v_q     <= '0;
          knz_q   <= NV'(1);
          onz_q   <= '0;
          for (int i = 0; i < NV; i++) begin
            keep_q[i] <= (i == 0) ? CNT_W'(1) : '0;
            owe_q[i]  <= '0;
          end
        end else begin
          v_q   <= v_q + VW'(1);
          knz_q <= knz_q >> 1;
          for (int i = 0; i < NV - 1; i++) begin
            keep_q[i] <= keep_q[i+1];
          end
          keep_q[NV-1] <= '0;
        end
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      val_q  <= VAL_W'(v_q);
      cnt_q  <= keep_q[0];
      last_q <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign valuation_o = val_q;
  assign count_o     = cnt_q;
  assign last_o      = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_RUN) |-> knz_q[0] && !onz_q[0])
    else $error("Bin zero of the no-borrow vector lost its count.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_EMIT) |-> !pop_o)
    else $error("Queue popped while the histogram is being sent.");

endmodule

`default_nettype wire

@@ hw/rtl/binomial_valuation_histogram_top.sv @@
// The front end divides the significant bytes of m once per base-p digit and takes no new item
// until it has divided the last one, which sets the rate; the top+1 output bins of one item
// overlap the next item's division and go out one per cycle unless the output stalls. The back
// end applies one digit per cycle across all valuation lanes while it is not sending bins and
// the queue holds an item. Reset clears all control state and puts a one in bin zero of the
// no-borrow vector. Top level: instantiates bvh_front, bvh_fifo, bvh_back; depends on bvh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module binomial_valuation_histogram_top #(
  parameter int M_BITS = 40
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire  [bvh_pkg::M_W-1:0]      m_value_i,
  input  wire  [bvh_pkg::BASE_W-1:0]   base_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [bvh_pkg::VAL_W-1:0]    valuation_o,
  output logic [bvh_pkg::CNT_W-1:0]    count_o,
  output logic                         last_o
);
  import bvh_pkg::*;

  q_entry_t  push_entry;
  q_entry_t  head;
  logic      push;
  logic      full;
  logic      pop;
  logic      empty;

  bvh_front #(
    .M_BITS (M_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .m_value_i  (m_value_i),
    .base_i     (base_i),
    .push_o     (push),
    .entry_o    (push_entry),
    .full_i     (full)
  );

  bvh_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty)
  );

  bvh_back #(
    .M_BITS (M_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .valuation_o (valuation_o),
    .count_o     (count_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

@@ verif/bvh_checker.sv @@
// Checker for the binomial valuation histogram block: watches both channels,
// predicts the histogram bins of every accepted item and compares the results.
// Depends on bvh_pkg for the field widths.
`timescale 1ns / 1ps

module bvh_checker #(
  parameter int M_BITS = 40
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  input  wire                          in_stall_i,
  input  wire  [bvh_pkg::M_W-1:0]      m_value_i,
  input  wire  [bvh_pkg::BASE_W-1:0]   base_i,
  input  wire                          out_valid_i,
  input  wire                          out_stall_i,
  input  wire  [bvh_pkg::VAL_W-1:0]    valuation_i,
  input  wire  [bvh_pkg::CNT_W-1:0]    count_i,
  input  wire                          last_i,
  output int                           errors_o,
  output int                           pending_o
);
  import bvh_pkg::*;

  localparam int NBINS = M_BITS + 2;

  typedef struct packed {
    logic [VAL_W-1:0] valuation;
    logic [CNT_W-1:0] count;
    logic             last;
  } hist_bin_t;

  hist_bin_t expected_bins[$];
  hist_bin_t want;
  int        error_count = 0;

  // Kummer digit DP: split m into base-p digits and track the count of t
  // with and without an outgoing borrow, indexed by the number of borrows.
  function automatic void predict_histogram(input logic [M_W-1:0] m,
                                            input logic [BASE_W-1:0] b);
    longint unsigned no_borrow[NBINS];
    longint unsigned borrow[NBINS];
    longint unsigned next_no_borrow[NBINS];
    longint unsigned next_borrow[NBINS];
    longint unsigned n;
    longint unsigned p;
    longint unsigned d;
    int              depth;
    int              top;
    hist_bin_t       bin;
    n     = 64'(m) & ((64'd1 << M_BITS) - 64'd1);
    p     = 64'(b);
    depth = 0;
    top   = 0;
    if (p < 2) begin
      p = 2;
    end
    for (int v = 0; v < NBINS; v++) begin
      no_borrow[v] = 0;
      borrow[v]    = 0;
    end
    no_borrow[0] = 1;
    while (n > 0 && depth < M_BITS) begin
      d = n % p;
      n = n / p;
      for (int v = 0; v < NBINS; v++) begin
        next_no_borrow[v] = 0;
        next_borrow[v]    = 0;
      end
      for (int v = 0; v <= depth && v + 1 < NBINS; v++) begin
        next_no_borrow[v]  += no_borrow[v] * (d + 1);
        next_borrow[v + 1] += no_borrow[v] * (p - 1 - d);
        next_no_borrow[v]  += borrow[v] * d;
        next_borrow[v + 1] += borrow[v] * (p - d);
      end
      for (int v = 0; v < NBINS; v++) begin
        no_borrow[v] = next_no_borrow[v];
        borrow[v]    = next_borrow[v];
      end
      depth++;
    end
    for (int v = 0; v < NBINS; v++) begin
      if (no_borrow[v] != 0) begin
        top = v;
      end
    end
    if (top > M_BITS) begin
      top = M_BITS;
    end
    for (int v = 0; v <= top; v++) begin
      bin.valuation = VAL_W'(v);
      bin.count     = CNT_W'(no_borrow[v]);
      bin.last      = (v == top);
      expected_bins = {expected_bins, bin};
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_bins.size() == 0) begin
          $display("%0t: unexpected result valuation=%0d count=%0d last=%0b",
                   $time, valuation_i, count_i, last_i);
          error_count++;
        end else begin
          want = expected_bins.pop_front();
          if (want.valuation !== valuation_i || want.count !== count_i ||
              want.last !== last_i) begin
            $display("%0t: mismatch expected (%0d, %0d, %0b) actual (%0d, %0d, %0b)",
                     $time, want.valuation, want.count, want.last,
                     valuation_i, count_i, last_i);
            error_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_histogram(m_value_i, base_i);
      end
    end
    errors_o  <= error_count;
    pending_o <= expected_bins.size();
  end

endmodule

@@ verif/binomial_valuation_histogram_top_tb.sv @@
// Testbench top for the binomial valuation histogram block: drives directed
// and random items with bursty input and patterned output stalls.
// Depends on bvh_pkg, binomial_valuation_histogram_top and bvh_checker.
`timescale 1ns / 1ps

module binomial_valuation_histogram_top_tb;
  import bvh_pkg::*;

  localparam int M_BITS       = 40;
  localparam int RANDOM_ITEMS = 400;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  typedef enum logic [1:0] {
    M_FULL,
    M_WIDTH,
    M_POWER,
    M_SMALL
  } m_shape_e;

  localparam logic [M_W-1:0] M_MAX = {M_W{1'b1}};

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [M_W-1:0]    m_value = '0;
  logic [BASE_W-1:0] base = 8'd2;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [VAL_W-1:0]  valuation;
  logic [CNT_W-1:0]  count;
  logic              last;
  int                errors;
  int                pending;

  stall_mode_e       stall_mode = STALL_NONE;
  int unsigned       stall_cycle = 0;

  logic [BASE_W-1:0] primes[] = '{8'd2, 8'd3, 8'd5, 8'd7, 8'd11, 8'd13, 8'd17, 8'd19,
                                  8'd23, 8'd29, 8'd31, 8'd37, 8'd41, 8'd53, 8'd67,
                                  8'd97, 8'd101, 8'd127, 8'd131, 8'd193, 8'd241,
                                  8'd251};

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  binomial_valuation_histogram_top #(
    .M_BITS(M_BITS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .m_value_i  (m_value),
    .base_i     (base),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .valuation_o(valuation),
    .count_o    (count),
    .last_o     (last)
  );

  bvh_checker #(
    .M_BITS(M_BITS)
  ) checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .m_value_i  (m_value),
    .base_i     (base),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .valuation_i(valuation),
    .count_i    (count),
    .last_i     (last),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  always @(posedge clk_i) begin
    stall_cycle <= stall_cycle + 1;
    if (stall_cycle % 256 == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
    end
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
      STALL_PERIODIC: out_stall <= (stall_cycle % 7 < 3);
      default:        out_stall <= 1'b0;
    endcase
  end

  task automatic send_item(input logic [M_W-1:0] m, input logic [BASE_W-1:0] b);
    m_value  <= m;
    base     <= b;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (in_stall) begin
      @(posedge clk_i);
    end
  endtask

  function automatic logic [BASE_W-1:0] pick_base();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) begin
      return primes[$urandom_range(0, primes.size() - 1)];
    end else if (sel < 9) begin
      return BASE_W'($urandom_range(2, 255));
    end
    return BASE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [M_W-1:0] pick_m(input logic [BASE_W-1:0] b);
    logic [63:0]     raw;
    longint unsigned pw;
    longint unsigned pb;
    int              k;
    raw = {$urandom, $urandom};
    pb  = (b < 2) ? 2 : 64'(b);
    pw  = 1;
    k   = $urandom_range(1, M_BITS);
    case (m_shape_e'($urandom_range(0, 3)))
      M_FULL:  return raw[M_W-1:0];
      M_WIDTH: return raw[M_W-1:0] >> $urandom_range(0, M_W);
      M_POWER: begin
        while (k > 0 && pw * pb <= 64'(M_MAX)) begin
          pw = pw * pb;
          k--;
        end
        return M_W'(pw + $urandom_range(0, 2) - 1);
      end
      default: return M_W'($urandom_range(0, 1000));
    endcase
  endfunction

  initial begin
    logic [M_W-1:0]    m;
    logic [BASE_W-1:0] b;
    int                burst_left;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item('0, 8'd2);
    send_item('0, 8'd255);
    send_item(40'd1, 8'd2);
    send_item(M_MAX, 8'd2);
    send_item(M_MAX, 8'd3);
    send_item(M_MAX, 8'd251);
    send_item(M_MAX, 8'd255);
    send_item(40'd5, 8'd0);
    send_item(40'd5, 8'd1);
    send_item(M_MAX, 8'd0);
    send_item(M_MAX, 8'd1);
    send_item(40'd100, 8'd4);
    send_item(M_MAX, 8'd6);
    send_item(M_MAX, 8'd254);
    send_item(40'd1000, 8'd255);
    send_item(40'h80_0000_0000, 8'd2);
    send_item(40'h7F_FFFF_FFFF, 8'd2);
    send_item(40'd250, 8'd251);
    send_item(40'd251, 8'd251);
    send_item(40'd63000, 8'd251);
    send_item(40'd847288609442, 8'd3);
    send_item(40'd847288609443, 8'd3);
    send_item(40'hAA_AAAA_AAAA, 8'd2);
    send_item(40'h55_5555_5555, 8'd7);
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 5)) @(posedge clk_i);

    burst_left = $urandom_range(1, 40);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      b = pick_base();
      m = pick_m(b);
      send_item(m, b);
      burst_left--;
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        burst_left = $urandom_range(1, 40);
      end
    end
    in_valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
